// ===== hdl/ttsg_pkg.sv =====
package ttsg_pkg;

	// level full scale, 100 percent in Q7.8
	localparam logic [14:0] LEVEL_MAX = 15'd25600;
	// 50 percent in Q7.8: one instance per step of peak load
	localparam logic [14:0] SCALE_STEP = 15'd12800;

	// direction codes
	localparam logic [1:0] DIR_UP   = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_NONE = 2'd2;

	// cause codes
	localparam logic [1:0] CAUSE_HIGH   = 2'd0;
	localparam logic [1:0] CAUSE_LOW    = 2'd1;
	localparam logic [1:0] CAUSE_NORMAL = 2'd2;
	localparam logic [1:0] CAUSE_TREND  = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MIN_COUNT   = 3'd0;
	localparam logic [2:0] REG_MAX_COUNT   = 3'd1;
	localparam logic [2:0] REG_CPU_HIGH    = 3'd2;
	localparam logic [2:0] REG_MEM_HIGH    = 3'd3;
	localparam logic [2:0] REG_CPU_LOW     = 3'd4;
	localparam logic [2:0] REG_MEM_LOW     = 3'd5;
	localparam logic [2:0] REG_SLOPE_LIMIT = 3'd6;

	typedef struct packed {
		logic [9:0]  min_count;
		logic [9:0]  max_count;
		logic [14:0] cpu_high;
		logic [14:0] mem_high;
		logic [14:0] cpu_low;
		logic [14:0] mem_low;
		logic [23:0] slope_limit;
	} cfg_t;

	// input word after level clamping
	typedef struct packed {
		logic        mode;
		logic [14:0] cpu_level;
		logic [14:0] mem_level;
		logic [1:0]  commit_direction;
		logic [9:0]  commit_target;
	} item_t;

	typedef struct packed {
		logic [1:0] direction;
		logic [1:0] cause;
		logic [9:0] count_before;
		logic [9:0] planned_count;
		logic [9:0] count_after;
	} result_t;

	// trend status of the window once the current sample is shifted in
	typedef struct packed {
		logic full;
		logic rising;
	} trend_t;

endpackage

// ===== hdl/ttsg_if.sv =====
// sample or commit word
interface ttsg_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [14:0] cpu_level;
	logic [14:0] mem_level;
	logic [1:0]  commit_direction;
	logic [9:0]  commit_target;

	modport source (output valid, mode, cpu_level, mem_level, commit_direction,
		commit_target, input ready);
	modport sink (input valid, mode, cpu_level, mem_level, commit_direction,
		commit_target, output ready);
endinterface

// plan word
interface ttsg_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] direction;
	logic [1:0] cause;
	logic [9:0] count_before;
	logic [9:0] planned_count;
	logic [9:0] count_after;

	modport source (output valid, direction, cause, count_before, planned_count,
		count_after, input ready);
	modport sink (input valid, direction, cause, count_before, planned_count,
		count_after, output ready);
endinterface

// ===== hdl/ttsg_trend.sv =====
// CPU window with running sums; slope numerator of the window after the
// current sample is shifted in is
//   N*sum(i*y) - S*sum(y),  S = N*(N-1)/2
module ttsg_trend #(
	parameter int WINDOW_LEN = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [14:0]       cpu_level,
	input  logic [23:0]       slope_limit,
	output ttsg_pkg::trend_t  trend
);

	localparam int LVL     = int'(ttsg_pkg::LEVEL_MAX);
	localparam int S       = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
	localparam int SUMY_W  = $clog2(WINDOW_LEN * LVL + 1);
	localparam int SUMIY_W = $clog2(LVL * S + 1);
	localparam int MAG_W   = $clog2(WINDOW_LEN * LVL * S + 1) + 1;
	localparam int NUM_W   = (MAG_W > 25) ? MAG_W : 25;
	localparam int FILL_W  = $clog2(WINDOW_LEN + 1);

	localparam logic [SUMIY_W-1:0] K_TOP   = SUMIY_W'(WINDOW_LEN - 1);
	localparam logic [NUM_W-1:0]   K_N     = NUM_W'(WINDOW_LEN);
	localparam logic [NUM_W-1:0]   K_S     = NUM_W'(S);
	localparam logic [FILL_W-1:0]  FILL_LAST = FILL_W'(WINDOW_LEN - 1);
	localparam logic [FILL_W-1:0]  FILL_TOP  = FILL_W'(WINDOW_LEN);

	logic [14:0]        win_q [WINDOW_LEN];
	logic [SUMY_W-1:0]  sum_y_q;
	logic [SUMIY_W-1:0] sum_iy_q;
	logic [FILL_W-1:0]  fill_q;

	logic [SUMY_W-1:0]  rest;
	logic [SUMY_W-1:0]  sum_y_nx;
	logic [SUMIY_W-1:0] sum_iy_nx;
	logic [NUM_W-1:0]   num;

	// sums after dropping the oldest tap and adding the new sample
	always_comb begin
		rest      = sum_y_q - SUMY_W'(win_q[0]);
		sum_y_nx  = rest + SUMY_W'(cpu_level);
		sum_iy_nx = sum_iy_q - SUMIY_W'(rest) + SUMIY_W'(cpu_level) * K_TOP;
		num       = NUM_W'(sum_iy_nx) * K_N - NUM_W'(sum_y_nx) * K_S;
	end

	assign trend.full   = (fill_q >= FILL_LAST);
	assign trend.rising = ($signed(num) > $signed(NUM_W'(slope_limit)));

	// window taps, sums and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			sum_y_q  <= '0;
			sum_iy_q <= '0;
			fill_q   <= '0;
		end else if (shift) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_LEN-1] <= cpu_level;
			sum_y_q  <= sum_y_nx;
			sum_iy_q <= sum_iy_nx;
			if (fill_q != FILL_TOP) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// sums track the taps: an empty window has zero sums
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (sum_y_q == '0 && sum_iy_q == '0))
		else $error("window sums nonzero while window empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shift && (fill_q == FILL_TOP) |=> (fill_q == FILL_TOP))
		else $error("fill count left saturation");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!shift |=> $stable(fill_q) && $stable(sum_y_q))
		else $error("window moved without a sample");

endmodule

// ===== hdl/ttsg_plan.sv =====
// plan decision for one word against the current count
module ttsg_plan (
	input  ttsg_pkg::item_t   item,
	input  ttsg_pkg::cfg_t    cfg,
	input  ttsg_pkg::trend_t  trend,
	input  logic [9:0]        count,
	output ttsg_pkg::result_t res,
	output logic [9:0]        count_nx
);

	logic [14:0] peak;
	logic [10:0] amount;
	logic [10:0] up_sum;
	logic [9:0]  up_cap;
	logic [10:0] one_sum;
	logic [9:0]  one_cap;
	logic [9:0]  down_cap;
	logic        is_high;
	logic        is_low;

	// clamped targets
	always_comb begin
		peak     = (item.cpu_level > item.mem_level) ? item.cpu_level : item.mem_level;
		amount   = (peak > ttsg_pkg::SCALE_STEP) ? 11'd2 : 11'd1;
		up_sum   = {1'b0, count} + amount;
		up_cap   = (up_sum > {1'b0, cfg.max_count}) ? cfg.max_count : up_sum[9:0];
		one_sum  = {1'b0, count} + 11'd1;
		one_cap  = (one_sum > {1'b0, cfg.max_count}) ? cfg.max_count : one_sum[9:0];
		down_cap = (count > cfg.min_count) ? (count - 10'd1) : cfg.min_count;
		is_high  = (item.cpu_level > cfg.cpu_high) || (item.mem_level > cfg.mem_high);
		is_low   = (item.cpu_level < cfg.cpu_low) && (item.mem_level < cfg.mem_low);
	end

	// decision
	always_comb begin
		res              = '0;
		count_nx         = count;
		res.count_before = count;
		if (item.mode) begin
			res.cause         = ttsg_pkg::CAUSE_NORMAL;
			res.planned_count = item.commit_target;
			if (item.commit_direction == ttsg_pkg::DIR_UP ||
				item.commit_direction == ttsg_pkg::DIR_DOWN) begin
				res.direction = item.commit_direction;
				count_nx      = item.commit_target;
			end else begin
				res.direction = ttsg_pkg::DIR_NONE;
			end
		end else if (is_high) begin
			res.direction     = ttsg_pkg::DIR_UP;
			res.cause         = ttsg_pkg::CAUSE_HIGH;
			res.planned_count = up_cap;
		end else if (is_low) begin
			res.direction     = ttsg_pkg::DIR_DOWN;
			res.cause         = ttsg_pkg::CAUSE_LOW;
			res.planned_count = down_cap;
		end else if (trend.full && trend.rising) begin
			res.direction     = ttsg_pkg::DIR_UP;
			res.cause         = ttsg_pkg::CAUSE_TREND;
			res.planned_count = one_cap;
		end else begin
			res.direction     = ttsg_pkg::DIR_NONE;
			res.cause         = ttsg_pkg::CAUSE_NORMAL;
			res.planned_count = count;
		end
		res.count_after = count_nx;
	end

endmodule

// ===== hdl/threshold_trend_scaling_governor.sv =====
// channel  | role | payload
// ---------+------+---------------------------------------------------------
// item     | in   | mode, cpu_level, mem_level, commit_direction, commit_target
// result   | out  | direction, cause, count_before, planned_count, count_after
// cfg_*    | in   | write enable, register index, 24-bit write data
//
// One word per cycle sustained while results are taken; an accepted word sits
// in the input register and is planned into the result register once that is
// free or being drained, and its plan is offered from the result register.
// Window sums are kept incrementally, so the slope check costs adds, subtracts
// and three constant multiplies regardless of WINDOW_LEN.
// arst_n clears the window, counts, valid flags and configuration registers to their defaults.
// A stalled result holds the plan stage; item.ready drops only when both
// the input register and the result register are full and the result is
// not being taken.
module threshold_trend_scaling_governor #(
	parameter int WINDOW_LEN = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	ttsg_item_if.sink      item,
	ttsg_result_if.source  result,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [23:0]    cfg_data
);

	ttsg_pkg::cfg_t      cfg_q;
	ttsg_pkg::item_t     item_s1;
	logic                v_s1;
	ttsg_pkg::result_t   res_s2;
	logic                v_s2;
	logic [9:0]          count_q;

	ttsg_pkg::item_t     item_in;
	ttsg_pkg::result_t   res_nx;
	ttsg_pkg::trend_t    trend;
	logic [9:0]          count_nx;
	logic                fire;

	// plan stage moves when the result register is free or being drained
	assign fire       = v_s1 && (!v_s2 || result.ready);
	assign item.ready = !v_s1 || fire;

	// clamp levels on entry
	always_comb begin
		item_in.mode             = item.mode;
		item_in.cpu_level        = (item.cpu_level > ttsg_pkg::LEVEL_MAX) ?
			ttsg_pkg::LEVEL_MAX : item.cpu_level;
		item_in.mem_level        = (item.mem_level > ttsg_pkg::LEVEL_MAX) ?
			ttsg_pkg::LEVEL_MAX : item.mem_level;
		item_in.commit_direction = item.commit_direction;
		item_in.commit_target    = item.commit_target;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_count   <= 10'd1;
			cfg_q.max_count   <= 10'd100;
			cfg_q.cpu_high    <= 15'd20480;
			cfg_q.mem_high    <= 15'd21760;
			cfg_q.cpu_low     <= 15'd5120;
			cfg_q.mem_low     <= 15'd7680;
			cfg_q.slope_limit <= 24'd21120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttsg_pkg::REG_MIN_COUNT:   cfg_q.min_count   <= cfg_data[9:0];
				ttsg_pkg::REG_MAX_COUNT:   cfg_q.max_count   <= cfg_data[9:0];
				ttsg_pkg::REG_CPU_HIGH:    cfg_q.cpu_high    <= cfg_data[14:0];
				ttsg_pkg::REG_MEM_HIGH:    cfg_q.mem_high    <= cfg_data[14:0];
				ttsg_pkg::REG_CPU_LOW:     cfg_q.cpu_low     <= cfg_data[14:0];
				ttsg_pkg::REG_MEM_LOW:     cfg_q.mem_low     <= cfg_data[14:0];
				ttsg_pkg::REG_SLOPE_LIMIT: cfg_q.slope_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
	end

	ttsg_trend #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_trend (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift       (fire && !item_s1.mode),
		.cpu_level   (item_s1.cpu_level),
		.slope_limit (cfg_q.slope_limit),
		.trend       (trend)
	);

	ttsg_plan u_plan (
		.item     (item_s1),
		.cfg      (cfg_q),
		.trend    (trend),
		.count    (count_q),
		.res      (res_nx),
		.count_nx (count_nx)
	);

	// instance count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 10'd1;
			v_s2    <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_nx;
			end
			if (fire) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nx;
		end
	end

	assign result.valid         = v_s2;
	assign result.direction     = res_s2.direction;
	assign result.cause         = res_s2.cause;
	assign result.count_before  = res_s2.count_before;
	assign result.planned_count = res_s2.planned_count;
	assign result.count_after   = res_s2.count_after;

	// samples never move the count
	a_sample_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item_s1.mode |=> $stable(count_q))
		else $error("sample word changed the instance count");
	// a held word is not dropped while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !fire |=> v_s1 && $stable(item_s1))
		else $error("pending word lost");
	// every plan lands in the result register with the count it left behind
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> v_s2 && (res_s2.count_after == count_q))
		else $error("result count_after disagrees with count");
	// commit words always report the normal cause
	a_commit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.mode |=> (res_s2.cause == ttsg_pkg::CAUSE_NORMAL))
		else $error("commit word reported a load cause");

endmodule
